// ===== design/elp_pkg.sv =====
// shared types and constants of the ellipse point generator
package elp_pkg;

    localparam int AXIS_BITS_DEF   = 10;
    localparam int COORD_BITS_DEF  = 12;
    localparam int CENTER_BITS     = 11;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_DEF    = (CENTER_BITS > AXIS_BITS_DEF) ? CENTER_BITS : AXIS_BITS_DEF;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_A   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_B   = 2'd3;

    typedef enum logic {
        CMD_STEP    = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== design/elp_if.sv =====
// channel interfaces: request input, point output and configuration write
interface elp_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface elp_out_if import elp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pt0_x;
    logic signed [COORD_BITS-1:0] pt0_y;
    logic signed [COORD_BITS-1:0] pt1_x;
    logic signed [COORD_BITS-1:0] pt1_y;
    logic signed [COORD_BITS-1:0] pt2_x;
    logic signed [COORD_BITS-1:0] pt2_y;
    logic signed [COORD_BITS-1:0] pt3_x;
    logic signed [COORD_BITS-1:0] pt3_y;
    logic                         region;
    logic                         last_point;

    modport source (
        output valid, output pt0_x, output pt0_y, output pt1_x, output pt1_y,
        output pt2_x, output pt2_y, output pt3_x, output pt3_y,
        output region, output last_point, input ready
    );
    modport sink (
        input valid, input pt0_x, input pt0_y, input pt1_x, input pt1_y,
        input pt2_x, input pt2_y, input pt3_x, input pt3_y,
        input region, input last_point, output ready
    );
endinterface

interface elp_cfg_if import elp_pkg::*; #(
    parameter int DATA_BITS = CFG_DATA_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/elp_front.sv =====
// front end: configuration registers, request accept and command classification
module elp_front import elp_pkg::*; #(
    parameter int AXIS_BITS = AXIS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    elp_in_if.sink                        i_in,
    elp_cfg_if.sink                       i_cfg,
    input  t_q_stat                       i_q_stat,
    output logic                          o_push,
    output t_cmd                          o_cmd,
    output logic signed [CENTER_BITS-1:0] o_cx,
    output logic signed [CENTER_BITS-1:0] o_cy,
    output logic [AXIS_BITS-1:0]          o_axis_a,
    output logic [AXIS_BITS-1:0]          o_axis_b
);

    logic signed [CENTER_BITS-1:0] r_cx;
    logic signed [CENTER_BITS-1:0] r_cy;
    logic [AXIS_BITS-1:0]          r_axis_a;
    logic [AXIS_BITS-1:0]          r_axis_b;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_stat.full;
    assign o_push      = i_in.valid && !i_q_stat.full;
    assign o_cmd       = i_in.restart ? CMD_RESTART : CMD_STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_axis_a <= '0;
            r_axis_b <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CENTER_X: begin
                    r_cx <= i_cfg.data[CENTER_BITS-1:0];
                end
                REG_CENTER_Y: begin
                    r_cy <= i_cfg.data[CENTER_BITS-1:0];
                end
                REG_AXIS_A: begin
                    r_axis_a <= i_cfg.data[AXIS_BITS-1:0];
                end
                REG_AXIS_B: begin
                    r_axis_b <= i_cfg.data[AXIS_BITS-1:0];
                end
                default: begin
                    r_cx <= r_cx;
                end
            endcase
        end
    end

    assign o_cx     = r_cx;
    assign o_cy     = r_cy;
    assign o_axis_a = r_axis_a;
    assign o_axis_b = r_axis_b;

endmodule

// ===== design/elp_fifo.sv =====
// short command queue between front end and back end (depth a power of two)
module elp_fifo import elp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_data,
    input  logic    i_pop,
    output t_cmd    o_data,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// ===== design/elp_back.sv =====
// back end: decision sequencer with one shared multiplier and output register
module elp_back import elp_pkg::*; #(
    parameter int AXIS_BITS  = AXIS_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_q_stat                       i_q_stat,
    input  t_cmd                          i_cmd,
    output logic                          o_pop,
    input  logic signed [CENTER_BITS-1:0] i_cx,
    input  logic signed [CENTER_BITS-1:0] i_cy,
    input  logic [AXIS_BITS-1:0]          i_axis_a,
    input  logic [AXIS_BITS-1:0]          i_axis_b,
    elp_out_if.source                     o_out
);

    localparam int MW   = 2 * AXIS_BITS + 2;
    localparam int DB   = 2 * MW;
    localparam int OB   = AXIS_BITS + 2;
    localparam int SQW  = 2 * AXIS_BITS;
    localparam int SW   = 2 * AXIS_BITS + 1;
    localparam int QW   = 4 * AXIS_BITS;
    localparam int MAXA = (COORD_BITS > OB) ? COORD_BITS : OB;
    localparam int MAXW = (MAXA > CENTER_BITS) ? MAXA : CENTER_BITS;
    localparam int SUMW = MAXW + 1;

    localparam logic [1:0] PH_ONE       = 2'd0;
    localparam logic [1:0] PH_TWO_START = 2'd1;
    localparam logic [1:0] PH_TWO       = 2'd2;
    localparam logic [1:0] PH_DONE      = 2'd3;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_R1   = 5'd1;
    localparam logic [4:0] S_R2   = 5'd2;
    localparam logic [4:0] S_R3   = 5'd3;
    localparam logic [4:0] S_R4   = 5'd4;
    localparam logic [4:0] S_R5   = 5'd5;
    localparam logic [4:0] S_R6   = 5'd6;
    localparam logic [4:0] S_P1   = 5'd7;
    localparam logic [4:0] S_P2   = 5'd8;
    localparam logic [4:0] S_P3   = 5'd9;
    localparam logic [4:0] S_W1   = 5'd10;
    localparam logic [4:0] S_W2   = 5'd11;
    localparam logic [4:0] S_W3   = 5'd12;
    localparam logic [4:0] S_T0   = 5'd13;
    localparam logic [4:0] S_Q1   = 5'd14;
    localparam logic [4:0] S_Q2   = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    localparam logic signed [MW-1:0] M_ONE   = MW'(1);
    localparam logic signed [MW-1:0] M_THREE = MW'(3);
    localparam logic signed [OB-1:0] X_ONE   = OB'(1);

    // control
    logic [4:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_ovalid, n_ovalid;

    // datapath
    logic [AXIS_BITS-1:0]         r_la, n_la;
    logic [AXIS_BITS-1:0]         r_lb, n_lb;
    logic [SQW-1:0]               r_a2, n_a2;
    logic [SQW-1:0]               r_b2, n_b2;
    logic [SW-1:0]                r_s, n_s;
    logic [QW-1:0]                r_a4, n_a4;
    logic signed [DB-1:0]         r_dec, n_dec;
    logic signed [DB-1:0]         r_d2, n_d2;
    logic signed [DB-1:0]         r_acc, n_acc;
    logic signed [DB-1:0]         r_prod, n_prod;
    logic signed [OB-1:0]         r_x, n_x;
    logic signed [OB-1:0]         r_y, n_y;
    logic                         r_reg, n_reg;
    logic                         r_last, n_last;
    logic signed [COORD_BITS-1:0] r_px, n_px;
    logic signed [COORD_BITS-1:0] r_mx, n_mx;
    logic signed [COORD_BITS-1:0] r_py, n_py;
    logic signed [COORD_BITS-1:0] r_my, n_my;
    logic                         r_reg_o, n_reg_o;
    logic                         r_last_o, n_last_o;

    // multiplier operands
    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [MW-1:0] w_xw, w_yw, w_la, w_lb, w_a2, w_b2, w_s, w_psq;
    logic signed [MW-1:0] w_x2p3, w_y2p3, w_1mx, w_1my, w_xp1, w_xm1, w_1m2a, w_1m2b;
    logic signed [MW-1:0] w_xnew;
    logic                 w_inside;
    logic                 w_dec_neg;
    logic                 w_out_free;
    logic signed [SUMW-1:0] w_cxs, w_cys, w_oxs, w_oys;
    logic signed [SUMW-1:0] w_px, w_mx, w_py, w_my;

    assign w_xw   = MW'(r_x);
    assign w_yw   = MW'(r_y);
    assign w_la   = $signed(MW'(r_la));
    assign w_lb   = $signed(MW'(r_lb));
    assign w_a2   = $signed(MW'(r_a2));
    assign w_b2   = $signed(MW'(r_b2));
    assign w_s    = $signed(MW'(r_s));
    assign w_psq  = r_prod[MW-1:0];
    assign w_x2p3 = (w_xw <<< 1) + M_THREE;
    assign w_y2p3 = (w_yw <<< 1) + M_THREE;
    assign w_1mx  = M_ONE - w_xw;
    assign w_1my  = M_ONE - w_yw;
    assign w_xp1  = w_xw + M_ONE;
    assign w_xm1  = w_xw - M_ONE;
    assign w_1m2a = M_ONE - (w_la <<< 1);
    assign w_1m2b = M_ONE - (w_lb <<< 1);
    assign w_dec_neg = r_dec[DB-1];
    assign w_xnew = w_dec_neg ? w_xw : w_xm1;

    // x^2 (a^2 + b^2) <= a^4
    assign w_inside = (r_prod <= $signed(DB'(r_a4)));

    assign w_out_free = !r_ovalid || o_out.ready;

    // four symmetric points, wrapped to the coordinate width
    assign w_cxs = SUMW'(i_cx);
    assign w_cys = SUMW'(i_cy);
    assign w_oxs = SUMW'(r_x);
    assign w_oys = SUMW'(r_y);
    assign w_px  = w_cxs + w_oxs;
    assign w_mx  = w_cxs - w_oxs;
    assign w_py  = w_cys + w_oys;
    assign w_my  = w_cys - w_oys;

    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_R1: begin
                w_ma = w_la;
                w_mb = w_la;
            end
            S_R2: begin
                w_ma = w_lb;
                w_mb = w_lb;
            end
            S_R3: begin
                w_ma = w_a2;
                w_mb = w_a2;
            end
            S_R4: begin
                w_ma = w_a2;
                w_mb = w_1m2b;
            end
            S_R5: begin
                w_ma = w_b2;
                w_mb = w_1m2a;
            end
            S_P1: begin
                w_ma = w_b2;
                w_mb = w_x2p3;
            end
            S_P2: begin
                w_ma = w_a2;
                w_mb = w_1my;
            end
            S_P3: begin
                w_ma = w_xp1;
                w_mb = w_xp1;
            end
            S_W1: begin
                w_ma = w_a2;
                w_mb = w_y2p3;
            end
            S_W2: begin
                w_ma = w_b2;
                w_mb = w_1mx;
            end
            S_W3: begin
                w_ma = w_xnew;
                w_mb = w_xnew;
            end
            S_T0: begin
                w_ma = w_la;
                w_mb = w_la;
            end
            S_Q1: begin
                w_ma = w_psq;
                w_mb = w_s;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign n_prod = w_ma * w_mb;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_ovalid = r_ovalid;
        n_la     = r_la;
        n_lb     = r_lb;
        n_a2     = r_a2;
        n_b2     = r_b2;
        n_s      = r_s;
        n_a4     = r_a4;
        n_dec    = r_dec;
        n_d2     = r_d2;
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_reg    = r_reg;
        n_last   = r_last;
        n_px     = r_px;
        n_mx     = r_mx;
        n_py     = r_py;
        n_my     = r_my;
        n_reg_o  = r_reg_o;
        n_last_o = r_last_o;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_cmd == CMD_RESTART) begin
                        n_la    = i_axis_a;
                        n_lb    = i_axis_b;
                        n_state = S_R1;
                    end else begin
                        case (r_phase)
                            PH_ONE:       n_state = S_P1;
                            PH_TWO_START: n_state = S_T0;
                            PH_TWO:       n_state = S_W1;
                            default:      n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_R1: begin
                n_state = S_R2;
            end
            S_R2: begin
                n_a2    = r_prod[SQW-1:0];
                n_state = S_R3;
            end
            S_R3: begin
                n_b2    = r_prod[SQW-1:0];
                n_s     = SW'(r_a2) + SW'(r_prod[SQW-1:0]);
                n_state = S_R4;
            end
            S_R4: begin
                n_a4    = r_prod[QW-1:0];
                n_state = S_R5;
            end
            S_R5: begin
                n_dec   = (DB'(w_b2) <<< 1) + r_prod;
                n_state = S_R6;
            end
            S_R6: begin
                n_d2   = (DB'(w_a2) <<< 1) + r_prod;
                n_x    = '0;
                n_y    = $signed(OB'(r_lb));
                n_reg  = 1'b0;
                n_last = (r_la == '0) && (r_lb == '0);
                n_phase = ((r_la == '0) && (r_lb == '0)) ? PH_DONE : PH_ONE;
                n_state = S_OUT;
            end
            S_P1: begin
                n_state = S_P2;
            end
            S_P2: begin
                n_acc   = r_dec + (r_prod <<< 1);
                n_state = S_P3;
            end
            S_P3: begin
                if (w_dec_neg) begin
                    n_dec = r_acc;
                end else begin
                    n_dec = r_acc + (r_prod <<< 2);
                    n_y   = r_y - X_ONE;
                end
                n_x     = r_x + X_ONE;
                n_state = S_Q1;
            end
            S_W1: begin
                n_state = S_W2;
            end
            S_W2: begin
                n_acc   = r_dec + (r_prod <<< 1);
                n_state = S_W3;
            end
            S_W3: begin
                if (w_dec_neg) begin
                    n_dec = r_acc;
                end else begin
                    n_dec = r_acc + (r_prod <<< 2);
                    n_x   = r_x - X_ONE;
                end
                n_y     = r_y + X_ONE;
                n_state = S_Q1;
            end
            S_T0: begin
                n_x     = $signed(OB'(r_la));
                n_y     = '0;
                n_dec   = r_d2;
                n_state = S_Q1;
            end
            S_Q1: begin
                n_state = S_Q2;
            end
            S_Q2: begin
                if (r_phase == PH_ONE) begin
                    n_phase = w_inside ? PH_ONE : PH_TWO_START;
                    n_reg   = 1'b0;
                    n_last  = 1'b0;
                end else begin
                    n_phase = w_inside ? PH_DONE : PH_TWO;
                    n_reg   = 1'b1;
                    n_last  = w_inside;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_px     = w_px[COORD_BITS-1:0];
                    n_mx     = w_mx[COORD_BITS-1:0];
                    n_py     = w_py[COORD_BITS-1:0];
                    n_my     = w_my[COORD_BITS-1:0];
                    n_reg_o  = r_reg;
                    n_last_o = r_last;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_DONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_a2     <= n_a2;
        r_b2     <= n_b2;
        r_s      <= n_s;
        r_a4     <= n_a4;
        r_dec    <= n_dec;
        r_d2     <= n_d2;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_x      <= n_x;
        r_y      <= n_y;
        r_reg    <= n_reg;
        r_last   <= n_last;
        r_px     <= n_px;
        r_mx     <= n_mx;
        r_py     <= n_py;
        r_my     <= n_my;
        r_reg_o  <= n_reg_o;
        r_last_o <= n_last_o;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.pt0_x      = r_px;
    assign o_out.pt0_y      = r_py;
    assign o_out.pt1_x      = r_mx;
    assign o_out.pt1_y      = r_py;
    assign o_out.pt2_x      = r_px;
    assign o_out.pt2_y      = r_my;
    assign o_out.pt3_x      = r_mx;
    assign o_out.pt3_y      = r_my;
    assign o_out.region     = r_reg_o;
    assign o_out.last_point = r_last_o;

    a_phase_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_phase) |-> ($past(r_state) == S_Q2 || $past(r_state) == S_R6))
        else $error("phase changed outside region test or setup");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

    a_region_two_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W3) |=> ((r_y == $past(r_y) + X_ONE) &&
            (r_x == $past(r_x) || r_x == $past(r_x) - X_ONE)))
        else $error("bad offset step in region two");

    a_region_one_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P1) |-> (r_phase == PH_ONE))
        else $error("region one step outside region one");

endmodule

// ===== design/ellipse_point_generator.sv =====
// ellipse point generator: top level
// Draws an axis-aligned ellipse with the two-region integer decision scheme.
// Configuration channel i_cfg writes center_x (0), center_y (1), axis_a (2)
// and axis_b (3); write it only while no request is in flight.
// Each request on i_in carries restart. A restart request latches the axes
// and yields the point (0, b) of region one; a step request yields the next
// point. Each result on o_out holds the four mirrored points around the
// center, the region and a last_point flag. Once last_point has been sent,
// step requests are consumed without a result until the next restart.
// The decision update and the region test use the single shared multiplier
// in turn; one request is worked on at a time.
// Requests are buffered in a short command queue, so i_in keeps accepting
// while the result register waits; when the receiver stalls the result is
// held and, once the queue fills, i_in.ready falls.
// Reset clears the queue and the output valid and leaves no ellipse active;
// the configuration registers reset to zero.
module ellipse_point_generator import elp_pkg::*; #(
    parameter int AXIS_BITS   = AXIS_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    elp_in_if.sink    i_in,
    elp_cfg_if.sink   i_cfg,
    elp_out_if.source o_out
);

    logic                          w_push;
    t_cmd                          w_push_cmd;
    logic                          w_pop;
    t_cmd                          w_pop_cmd;
    t_q_stat                       w_q_stat;
    logic signed [CENTER_BITS-1:0] w_cx;
    logic signed [CENTER_BITS-1:0] w_cy;
    logic [AXIS_BITS-1:0]          w_axis_a;
    logic [AXIS_BITS-1:0]          w_axis_b;

    elp_front #(
        .AXIS_BITS (AXIS_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd),
        .o_cx     (w_cx),
        .o_cy     (w_cy),
        .o_axis_a (w_axis_a),
        .o_axis_b (w_axis_b)
    );

    elp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_pop_cmd),
        .o_stat  (w_q_stat)
    );

    elp_back #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_cmd    (w_pop_cmd),
        .o_pop    (w_pop),
        .i_cx     (w_cx),
        .i_cy     (w_cy),
        .i_axis_a (w_axis_a),
        .i_axis_b (w_axis_b),
        .o_out    (o_out)
    );

endmodule
